/* hw/rtl/lmfe_pkg.sv */
// Shared types, codes and helpers for the LIN master frame engine.
// No dependencies; imported by every module of the block.
package lmfe_pkg;

  localparam int MAX_DATA_BYTES_DEF = 8;
  localparam int MAX_RESULTS = 4;
  localparam int QUEUE_DEPTH = 8;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

  localparam logic [15:0] TIMEOUT_RESET = 16'd17360;
  localparam logic [7:0] SYNC_BYTE = 8'h55;
  localparam logic [16:0] TICK_US = 17'd100;

  localparam logic [2:0] OP_START_SEND = 3'd0;
  localparam logic [2:0] OP_SEND_BYTE = 3'd1;
  localparam logic [2:0] OP_START_RECV = 3'd2;
  localparam logic [2:0] OP_BUS_BYTE = 3'd3;
  localparam logic [2:0] OP_TICK = 3'd4;

  localparam logic [1:0] KIND_BREAK = 2'd0;
  localparam logic [1:0] KIND_TX = 2'd1;
  localparam logic [1:0] KIND_RX = 2'd2;
  localparam logic [1:0] KIND_STATUS = 2'd3;

  localparam logic [2:0] ST_NO_SYNC = 3'd0;
  localparam logic [2:0] ST_NO_ID = 3'd1;
  localparam logic [2:0] ST_TIMEOUT = 3'd2;
  localparam logic [2:0] ST_BAD_SUM = 3'd3;
  localparam logic [2:0] ST_OK = 3'd4;

  localparam logic [2:0] REG_TIMEOUT_LIMIT = 3'd0;

  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_SEND  = 6'b000010,
    PH_SYNC  = 6'b000100,
    PH_ID    = 6'b001000,
    PH_DATA  = 6'b010000,
    PH_CHECK = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_value;
    logic [2:0] byte_index;
    logic [2:0] status;
    logic [3:0] bytes_received;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [2:0]                     count;
    result_t [MAX_RESULTS-1:0]      entry;
  } result_group_t;

  function automatic logic [7:0] make_pid(input logic [5:0] id);
    logic p0;
    logic p1;
    p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
    p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
    return {p1, p0, id};
  endfunction

  function automatic logic [7:0] add_carry(input logic [7:0] acc, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, acc} + {1'b0, b};
    return s[8] ? (s[7:0] + 8'd1) : s[7:0];
  endfunction

  function automatic result_t make_result(input logic [1:0] kind, input logic [7:0] val,
                                          input logic [2:0] idx, input logic [2:0] st,
                                          input logic [3:0] nrx, input logic last);
    result_t r;
    r.kind = kind;
    r.byte_value = val;
    r.byte_index = idx;
    r.status = st;
    r.bytes_received = nrx;
    r.last = last;
    return r;
  endfunction

endpackage

/* hw/rtl/lmfe_core.sv */
// Frame sequencer: phase, checksum, byte counter and receive timer.
// Depends on lmfe_pkg; turns one request into a group of up to four results.
module lmfe_core
  import lmfe_pkg::*;
#(
  parameter int MAX_DATA_BYTES = MAX_DATA_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          take,
  input  logic [2:0]    op,
  input  logic [5:0]    frame_id,
  input  logic [3:0]    data_length,
  input  logic          classic_checksum,
  input  logic [7:0]    data_byte,
  input  logic [15:0]   timeout_limit,
  output result_group_t group
);

  localparam logic [3:0] MaxLen = 4'(MAX_DATA_BYTES);

  phase_t      phase, phase_next;
  logic [7:0]  protected_id, protected_id_next;
  logic [7:0]  checksum_acc, checksum_acc_next;
  logic [3:0]  byte_count, byte_count_next;
  logic [3:0]  frame_length, frame_length_next;
  logic [15:0] elapsed_time, elapsed_time_next;

  logic [7:0]  pid;
  logic [3:0]  len;
  logic [7:0]  seed;
  logic [7:0]  acc_add;
  logic [3:0]  count_inc;
  logic [16:0] time_sum;
  logic [15:0] time_sat;
  logic [2:0]  tmo_status;
  logic [3:0]  tmo_count;

  always_comb begin
    pid = make_pid(frame_id);
    len = (data_length > MaxLen) ? MaxLen : data_length;
    seed = classic_checksum ? 8'd0 : pid;
    acc_add = add_carry(checksum_acc, data_byte);
    count_inc = byte_count + 4'd1;
    time_sum = {1'b0, elapsed_time} + TICK_US;
    time_sat = time_sum[16] ? 16'hffff : time_sum[15:0];
    tmo_status = (phase == PH_SYNC) ? ST_NO_SYNC : ((phase == PH_ID) ? ST_NO_ID : ST_TIMEOUT);
    tmo_count = (phase == PH_SYNC || phase == PH_ID) ? 4'd0 : byte_count;

    phase_next = phase;
    protected_id_next = protected_id;
    checksum_acc_next = checksum_acc;
    byte_count_next = byte_count;
    frame_length_next = frame_length;
    elapsed_time_next = elapsed_time;
    group = '0;

    if (take) begin
      case (op)
        OP_START_SEND, OP_START_RECV: begin
          protected_id_next = pid;
          byte_count_next = 4'd0;
          frame_length_next = len;
          group.entry[0] = make_result(KIND_BREAK, 8'd0, 3'd0, 3'd0, 4'd0, 1'b0);
          group.entry[1] = make_result(KIND_TX, SYNC_BYTE, 3'd0, 3'd0, 4'd0, 1'b0);
          group.entry[2] = make_result(KIND_TX, pid, 3'd0, 3'd0, 4'd0, 1'b0);
          group.count = 3'd3;
          if (op == OP_START_SEND) begin
            checksum_acc_next = seed;
            if (len == 4'd0) begin
              group.entry[3] = make_result(KIND_TX, ~seed, 3'd0, 3'd0, 4'd0, 1'b1);
              group.count = 3'd4;
              phase_next = PH_IDLE;
            end else begin
              phase_next = PH_SEND;
            end
          end else begin
            checksum_acc_next = pid;
            elapsed_time_next = 16'd0;
            phase_next = PH_SYNC;
          end
        end
        OP_SEND_BYTE: begin
          if (phase == PH_SEND) begin
            checksum_acc_next = acc_add;
            byte_count_next = count_inc;
            group.entry[0] = make_result(KIND_TX, data_byte, 3'd0, 3'd0, 4'd0, 1'b0);
            group.count = 3'd1;
            if (count_inc >= frame_length) begin
              group.entry[1] = make_result(KIND_TX, ~acc_add, 3'd0, 3'd0, 4'd0, 1'b1);
              group.count = 3'd2;
              phase_next = PH_IDLE;
            end
          end
        end
        OP_BUS_BYTE: begin
          case (phase)
            PH_SYNC: begin
              if (data_byte == SYNC_BYTE) phase_next = PH_ID;
            end
            PH_ID: begin
              if (data_byte == protected_id) begin
                phase_next = (frame_length == 4'd0) ? PH_CHECK : PH_DATA;
              end
            end
            PH_DATA: begin
              group.entry[0] = make_result(KIND_RX, data_byte, byte_count[2:0], 3'd0, 4'd0,
                                           1'b0);
              group.count = 3'd1;
              checksum_acc_next = acc_add;
              byte_count_next = count_inc;
              if (count_inc >= frame_length) phase_next = PH_CHECK;
            end
            PH_CHECK: begin
              byte_count_next = count_inc;
              group.entry[0] = make_result(KIND_STATUS, 8'd0, 3'd0,
                                           (~checksum_acc == data_byte) ? ST_OK : ST_BAD_SUM,
                                           count_inc, 1'b1);
              group.count = 3'd1;
              phase_next = PH_IDLE;
            end
            default: begin
            end
          endcase
        end
        OP_TICK: begin
          if (phase == PH_SYNC || phase == PH_ID || phase == PH_DATA || phase == PH_CHECK) begin
            elapsed_time_next = time_sat;
            if (time_sat >= timeout_limit) begin
              group.entry[0] = make_result(KIND_STATUS, 8'd0, 3'd0, tmo_status, tmo_count,
                                           1'b1);
              group.count = 3'd1;
              phase_next = PH_IDLE;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      protected_id <= 8'd0;
      checksum_acc <= 8'd0;
      byte_count <= 4'd0;
      frame_length <= 4'd0;
      elapsed_time <= 16'd0;
    end else begin
      phase <= phase_next;
      protected_id <= protected_id_next;
      checksum_acc <= checksum_acc_next;
      byte_count <= byte_count_next;
      frame_length <= frame_length_next;
      elapsed_time <= elapsed_time_next;
    end
  end

endmodule

/* hw/rtl/lmfe_result_queue.sv */
// Result queue: takes a group of up to four results a cycle, gives one.
// Depends on lmfe_pkg for the result types and queue depth.
module lmfe_result_queue
  import lmfe_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  result_group_t group,
  input  logic          pop,
  output result_t       head,
  output logic          not_empty,
  output logic          has_room
);

  result_t               slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [QUEUE_AW:0]     fill, fill_next;

  assign head = slots[rd_ptr];
  assign not_empty = (fill != '0);
  assign has_room = (fill <= (QUEUE_AW+1)'(QUEUE_DEPTH - MAX_RESULTS));

  always_comb begin
    fill_next = fill + (QUEUE_AW+1)'(group.count) - (QUEUE_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (3'(i) < group.count) slots[wr_ptr + QUEUE_AW'(i)] <= group.entry[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      wr_ptr <= wr_ptr + QUEUE_AW'(group.count);
      rd_ptr <= rd_ptr + QUEUE_AW'(pop);
      fill <= fill_next;
    end
  end

endmodule

/* hw/rtl/lin_master_frame_engine_top.sv */
// LIN master frame engine top level: request channel, result channel, APB register.
// Latency: results reach the result port from the next cycle, one per unstalled cycle.
// Throughput: one request per cycle while the eight-entry result queue has room for four;
// a request yields up to four results, so the result side sets the sustained rate.
// Reset clears phase, checksum, counters, timer, queue and timeout_limit (to 17360).
// Depends on lmfe_pkg, lmfe_core and lmfe_result_queue.
module lin_master_frame_engine_top
  import lmfe_pkg::*;
#(
  parameter int MAX_DATA_BYTES = MAX_DATA_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  op,
  input  logic [5:0]  frame_id,
  input  logic [3:0]  data_length,
  input  logic        classic_checksum,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  byte_value,
  output logic [2:0]  byte_index,
  output logic [2:0]  status,
  output logic [3:0]  bytes_received,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0]   timeout_limit;
  logic          take;
  logic          room;
  result_group_t group;
  result_t       head;

  assign pready = 1'b1;
  assign prdata = (paddr == {REG_TIMEOUT_LIMIT[0], 2'b00}) ? {16'd0, timeout_limit} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit <= TIMEOUT_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_TIMEOUT_LIMIT[0]) begin
      timeout_limit <= pwdata[15:0];
    end
  end

  assign in_stall = !room;
  assign take = in_valid && room;

  lmfe_core #(
    .MAX_DATA_BYTES(MAX_DATA_BYTES)
  ) u_core (
    .clk              (clk),
    .rst              (rst),
    .take             (take),
    .op               (op),
    .frame_id         (frame_id),
    .data_length      (data_length),
    .classic_checksum (classic_checksum),
    .data_byte        (data_byte),
    .timeout_limit    (timeout_limit),
    .group            (group)
  );

  lmfe_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .group     (group),
    .pop       (out_valid && !out_stall),
    .head      (head),
    .not_empty (out_valid),
    .has_room  (room)
  );

  assign kind = head.kind;
  assign byte_value = head.byte_value;
  assign byte_index = head.byte_index;
  assign status = head.status;
  assign bytes_received = head.bytes_received;
  assign last = head.last;

endmodule

/* hw/rtl/lmfe_checker.sv */
// Port-level checks for the LIN master frame engine result channel.
// Depends on lmfe_pkg; bound to lin_master_frame_engine_top below.
module lmfe_checker
  import lmfe_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] kind,
  input logic [7:0] byte_value,
  input logic [2:0] status,
  input logic       last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(byte_value) &&
    $stable(status) && $stable(last))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_STATUS |-> last && status <= ST_OK)
    else $error("receive status not closing frame");

  a_break_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_BREAK |-> byte_value == 8'd0 && !last)
    else $error("break result carries data");

  a_rx_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_RX |-> status == 3'd0 && !last)
    else $error("received byte carries status");

endmodule

bind lin_master_frame_engine_top lmfe_checker u_lmfe_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .kind       (kind),
  .byte_value (byte_value),
  .status     (status),
  .last       (last)
);

/* sim/tb.sv */
// Testbench for lin_master_frame_engine_top: random and directed send/receive frames
// checked result by result against an in-bench frame predictor, timeout_limit over APB.
// Depends on lmfe_pkg and the lin_master_frame_engine_top RTL.
module tb;
  import lmfe_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 12;
  localparam logic [2:0] TIMEOUT_LIMIT_ADDR = 3'(4 * REG_TIMEOUT_LIMIT);

  typedef struct packed {
    logic [2:0] op;
    logic [5:0] id;
    logic [3:0] len;
    logic       cls;
    logic [7:0] data;
  } lin_req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  op = '0;
  logic [5:0]  frame_id = '0;
  logic [3:0]  data_length = '0;
  logic        classic_checksum = 1'b0;
  logic [7:0]  data_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  byte_value;
  logic [2:0]  byte_index;
  logic [2:0]  status;
  logic [3:0]  bytes_received;
  logic        last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  lin_master_frame_engine_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .frame_id(frame_id), .data_length(data_length),
    .classic_checksum(classic_checksum), .data_byte(data_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .byte_value(byte_value), .byte_index(byte_index),
    .status(status), .bytes_received(bytes_received), .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  lin_req_t pending_req_q[$];
  result_t  frame_result_q[$];
  int       items_added = 0;
  int       mismatches = 0;
  int       quiet_cycles = 0;
  logic     in_taken = 1'b0;
  logic     out_taken = 1'b0;
  int       send_gap = 0;
  int       recv_gap = 0;
  bit       send_burst = 1'b0;
  bit       recv_burst = 1'b0;

  phase_t      fr_phase = PH_IDLE;
  logic [7:0]  fr_pid = '0;
  logic [7:0]  fr_sum = '0;
  logic [3:0]  fr_count = '0;
  logic [3:0]  fr_len = '0;
  logic [15:0] fr_elapsed_us = '0;
  logic [15:0] fr_timeout_us = TIMEOUT_RESET;

  function automatic logic [7:0] lin_pid(input logic [5:0] id);
    return {~^(id & 6'b111010), ^(id & 6'b010111), id};
  endfunction

  function automatic logic [7:0] lin_sum_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s > 9'd255) s = s - 9'd255;
    return s[7:0];
  endfunction

  function automatic logic [3:0] lin_clamp_len(input logic [3:0] len);
    return (len > MAX_DATA_BYTES_DEF) ? 4'(MAX_DATA_BYTES_DEF) : len;
  endfunction

  function automatic void expect_result(input logic [1:0] k, input logic [7:0] v,
                                        input logic [2:0] idx, input logic [2:0] st,
                                        input logic [3:0] nrx, input logic lst);
    result_t r;
    r.kind = k;
    r.byte_value = v;
    r.byte_index = idx;
    r.status = st;
    r.bytes_received = nrx;
    r.last = lst;
    frame_result_q.push_back(r);
  endfunction

  function automatic void expect_header(input logic [5:0] id);
    fr_pid = lin_pid(id);
    expect_result(KIND_BREAK, 8'h00, 3'd0, 3'd0, 4'd0, 1'b0);
    expect_result(KIND_TX, SYNC_BYTE, 3'd0, 3'd0, 4'd0, 1'b0);
    expect_result(KIND_TX, fr_pid, 3'd0, 3'd0, 4'd0, 1'b0);
    fr_count = '0;
  endfunction

  function automatic void predict_frame_step(input lin_req_t r);
    logic [16:0] e;
    logic [2:0]  st;
    logic [3:0]  nrx;
    case (r.op)
      OP_START_SEND: begin
        expect_header(r.id);
        fr_len = lin_clamp_len(r.len);
        fr_sum = r.cls ? 8'h00 : fr_pid;
        if (fr_len == 4'd0) begin
          expect_result(KIND_TX, ~fr_sum, 3'd0, 3'd0, 4'd0, 1'b1);
          fr_phase = PH_IDLE;
        end else begin
          fr_phase = PH_SEND;
        end
      end
      OP_SEND_BYTE: begin
        if (fr_phase == PH_SEND) begin
          fr_sum = lin_sum_add(fr_sum, r.data);
          fr_count = fr_count + 4'd1;
          expect_result(KIND_TX, r.data, 3'd0, 3'd0, 4'd0, 1'b0);
          if (fr_count >= fr_len) begin
            expect_result(KIND_TX, ~fr_sum, 3'd0, 3'd0, 4'd0, 1'b1);
            fr_phase = PH_IDLE;
          end
        end
      end
      OP_START_RECV: begin
        expect_header(r.id);
        fr_len = lin_clamp_len(r.len);
        fr_sum = fr_pid;
        fr_elapsed_us = '0;
        fr_phase = PH_SYNC;
      end
      OP_BUS_BYTE: begin
        case (fr_phase)
          PH_SYNC: if (r.data == SYNC_BYTE) fr_phase = PH_ID;
          PH_ID: begin
            if (r.data == fr_pid) fr_phase = (fr_len == 4'd0) ? PH_CHECK : PH_DATA;
          end
          PH_DATA: begin
            expect_result(KIND_RX, r.data, fr_count[2:0], 3'd0, 4'd0, 1'b0);
            fr_sum = lin_sum_add(fr_sum, r.data);
            fr_count = fr_count + 4'd1;
            if (fr_count >= fr_len) fr_phase = PH_CHECK;
          end
          PH_CHECK: begin
            fr_count = fr_count + 4'd1;
            expect_result(KIND_STATUS, 8'h00, 3'd0,
                          (~fr_sum == r.data) ? ST_OK : ST_BAD_SUM, fr_count, 1'b1);
            fr_phase = PH_IDLE;
          end
          default: ;
        endcase
      end
      OP_TICK: begin
        if (fr_phase == PH_SYNC || fr_phase == PH_ID || fr_phase == PH_DATA ||
            fr_phase == PH_CHECK) begin
          e = {1'b0, fr_elapsed_us} + TICK_US;
          if (e > 17'h0ffff) e = 17'h0ffff;
          fr_elapsed_us = e[15:0];
          if (fr_elapsed_us >= fr_timeout_us) begin
            st = (fr_phase == PH_SYNC) ? ST_NO_SYNC : (fr_phase == PH_ID) ? ST_NO_ID : ST_TIMEOUT;
            nrx = (fr_phase == PH_SYNC || fr_phase == PH_ID) ? 4'd0 : fr_count;
            expect_result(KIND_STATUS, 8'h00, 3'd0, st, nrx, 1'b1);
            fr_phase = PH_IDLE;
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_result();
    result_t want;
    if (frame_result_q.size() == 0) begin
      report_mismatch("result with nothing pending, kind", int'(kind), -1);
    end else begin
      want = frame_result_q.pop_front();
      if (kind !== want.kind) report_mismatch("kind", int'(kind), int'(want.kind));
      if (byte_value !== want.byte_value) begin
        report_mismatch("byte_value", int'(byte_value), int'(want.byte_value));
      end
      if (byte_index !== want.byte_index) begin
        report_mismatch("byte_index", int'(byte_index), int'(want.byte_index));
      end
      if (status !== want.status) report_mismatch("status", int'(status), int'(want.status));
      if (bytes_received !== want.bytes_received) begin
        report_mismatch("bytes_received", int'(bytes_received), int'(want.bytes_received));
      end
      if (last !== want.last) report_mismatch("last", int'(last), int'(want.last));
    end
  endtask

  always @(posedge clk) begin
    lin_req_t cur;
    in_taken <= !rst && in_valid && !in_stall;
    out_taken <= !rst && out_valid && !out_stall;
    if (!rst) begin
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) begin
        cur = '{op, frame_id, data_length, classic_checksum, data_byte};
        predict_frame_step(cur);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("simulation failed");
          $finish;
        end
      end
    end
  end

  always @(negedge clk) begin
    lin_req_t nxt;
    logic v;
    v = in_valid;
    if (!rst) begin
      if (in_valid && in_taken) v = 1'b0;
      if (!v) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (pending_req_q.size() != 0) begin
          nxt = pending_req_q.pop_front();
          op <= nxt.op;
          frame_id <= nxt.id;
          data_length <= nxt.len;
          classic_checksum <= nxt.cls;
          data_byte <= nxt.data;
          v = 1'b1;
          if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
          send_gap = send_burst ? 0 : $urandom_range(0, 13);
        end
      end
    end
    in_valid <= v;
  end

  always @(negedge clk) begin
    if (out_taken) begin
      if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
      recv_gap = recv_burst ? 0 : $urandom_range(0, 13);
    end else if (recv_gap != 0) begin
      recv_gap--;
    end
    out_stall <= (recv_gap != 0);
  end

  task automatic add_req(input logic [2:0] o, input logic [5:0] id, input logic [3:0] len,
                         input logic cls, input logic [7:0] b);
    lin_req_t r;
    r = '{o, id, len, cls, b};
    pending_req_q.push_back(r);
    items_added++;
  endtask

  task automatic add_bus(input logic [7:0] b);
    add_req(OP_BUS_BYTE, 6'($urandom), 4'($urandom), 1'($urandom), b);
  endtask

  task automatic maybe_tick(input int pct);
    if ($urandom_range(0, 99) < pct) begin
      add_req(OP_TICK, 6'($urandom), 4'($urandom), 1'($urandom), 8'($urandom));
    end
  endtask

  task automatic add_send_frame(input logic [5:0] id, input logic [3:0] len, input logic cls,
                                input int nbytes);
    add_req(OP_START_SEND, id, len, cls, 8'($urandom));
    for (int i = 0; i < nbytes; i++) begin
      if ($urandom_range(0, 9) == 0) add_req(3'($urandom_range(3, 7)), 6'($urandom),
                                             4'($urandom), 1'($urandom), 8'($urandom));
      add_req(OP_SEND_BYTE, 6'($urandom), 4'($urandom), 1'($urandom), 8'($urandom));
    end
  endtask

  task automatic add_recv_frame(input logic [5:0] id, input logic [3:0] len,
                                input bit good_sum, input int tick_pct);
    logic [7:0] pid;
    logic [7:0] sum;
    logic [7:0] b;
    int n;
    int stop;
    pid = lin_pid(id);
    n = int'(lin_clamp_len(len));
    stop = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, n)) : n + 1;
    add_req(OP_START_RECV, id, len, 1'($urandom), 8'($urandom));
    repeat ($urandom_range(0, 2)) begin
      b = 8'($urandom);
      if (b == SYNC_BYTE) b = 8'h54;
      maybe_tick(tick_pct);
      add_bus(b);
    end
    maybe_tick(tick_pct);
    add_bus(SYNC_BYTE);
    if (stop == 0) return;
    if ($urandom_range(0, 3) == 0) add_bus(pid ^ (8'd1 << $urandom_range(0, 7)));
    maybe_tick(tick_pct);
    add_bus(pid);
    sum = pid;
    for (int i = 0; i < n; i++) begin
      if (stop == i + 1) return;
      b = 8'($urandom);
      sum = lin_sum_add(sum, b);
      maybe_tick(tick_pct);
      add_bus(b);
    end
    maybe_tick(tick_pct);
    add_bus(good_sum ? ~sum : ~sum ^ (8'd1 << $urandom_range(0, 7)));
  endtask

  task automatic add_random_frames(input int count, input int tick_pct);
    int goal;
    int sel;
    logic [3:0] len;
    goal = items_added + count;
    while (items_added < goal) begin
      sel = $urandom_range(0, 99);
      len = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
      if (sel < 35) begin
        add_send_frame(6'($urandom), len, 1'($urandom),
                       ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, lin_clamp_len(len)))
                                                   : int'(lin_clamp_len(len)));
      end else if (sel < 85) begin
        add_recv_frame(6'($urandom), len, $urandom_range(0, 4) != 0, tick_pct);
      end else begin
        add_req(3'($urandom_range(0, 7)), 6'($urandom), 4'($urandom_range(0, 15)),
                1'($urandom), 8'($urandom));
      end
    end
  endtask

  task automatic write_timeout_limit(input logic [15:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= TIMEOUT_LIMIT_ADDR;
    pwdata <= {16'h0000, value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    fr_timeout_us = value;
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[15:0] !== value) begin
      report_mismatch("timeout_limit readback", int'(prdata[15:0]), int'(value));
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_frames_done();
    while (pending_req_q.size() != 0 || in_valid || frame_result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [7:0] pattern [8];
    logic [7:0] pid;
    logic [7:0] sum;
    pattern = '{8'hff, 8'h00, 8'hff, 8'h80, 8'h01, 8'haa, 8'h55, 8'hfe};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_timeout_limit(TIMEOUT_RESET);
    add_req(OP_START_SEND, 6'h00, 4'd0, 1'b0, 8'h00);
    add_req(OP_START_SEND, 6'h3f, 4'd15, 1'b1, 8'hff);
    foreach (pattern[i]) add_req(OP_SEND_BYTE, 6'h00, 4'd0, 1'b0, pattern[i]);
    add_req(OP_SEND_BYTE, 6'h3f, 4'd15, 1'b1, 8'hff);
    add_req(OP_BUS_BYTE, 6'h3f, 4'd15, 1'b1, SYNC_BYTE);
    add_req(OP_TICK, 6'h3f, 4'd15, 1'b1, 8'hff);
    pid = lin_pid(6'h3c);
    add_req(OP_START_RECV, 6'h3c, 4'd2, 1'b1, 8'h00);
    add_bus(8'h12);
    add_bus(SYNC_BYTE);
    add_bus(pid ^ 8'h80);
    add_bus(pid);
    add_bus(8'hff);
    add_bus(8'hff);
    add_bus(~lin_sum_add(lin_sum_add(pid, 8'hff), 8'hff));
    pid = lin_pid(6'h15);
    add_req(OP_START_RECV, 6'h15, 4'd0, 1'b0, 8'h00);
    add_bus(SYNC_BYTE);
    add_bus(pid);
    add_bus(~pid ^ 8'h01);
    wait_frames_done();

    write_timeout_limit(16'd0);
    add_random_frames(25, 15);
    wait_frames_done();

    write_timeout_limit(16'd300);
    add_random_frames(50, 15);
    wait_frames_done();

    write_timeout_limit(16'hffff);
    pid = lin_pid(6'h2a);
    sum = lin_sum_add(pid, 8'h5a);
    add_req(OP_START_RECV, 6'h2a, 4'd2, 1'b0, 8'h00);
    add_bus(SYNC_BYTE);
    add_bus(pid);
    add_bus(8'h5a);
    repeat (40) add_req(OP_TICK, 6'($urandom), 4'($urandom), 1'($urandom), 8'($urandom));
    add_bus(~sum);
    add_random_frames(20, 10);
    wait_frames_done();

    write_timeout_limit(16'($urandom_range(100, 1500)));
    add_random_frames(35, 20);
    wait_frames_done();

    write_timeout_limit(16'($urandom_range(0, 65535)));
    add_random_frames(35, 15);
    wait_frames_done();

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/lmfe_pkg.sv
hw/rtl/lmfe_core.sv
hw/rtl/lmfe_result_queue.sv
hw/rtl/lin_master_frame_engine_top.sv
hw/rtl/lmfe_checker.sv
sim/tb.sv
